FILE: rtl/epp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder preset positioner: shared package
// Command and direction codes, state and result records used by the core
// and its step logic.
// ----------------------------------------------------------------------------
package epp_pkg;

	localparam int unsigned POS_W   = 32;
	localparam int unsigned LEVEL_W = 8;
	localparam int unsigned CMD_W   = 3;

	localparam logic [LEVEL_W-1:0] DRIVE_LEVEL_RST = 8'hFF;

	// Item kinds carried on the input tuser
	typedef enum logic [CMD_W-1:0] {
		CMD_EDGE = 3'd0,
		CMD_UP   = 3'd1,
		CMD_DOWN = 3'd2,
		CMD_STOP = 3'd3,
		CMD_GOTO = 3'd4,
		CMD_SAVE = 3'd5
	} cmd_t;

	// Motor / seek direction
	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_UP   = 2'd1,
		DIR_DOWN = 2'd2
	} dir_t;

	// Architectural state of the positioner
	typedef struct packed {
		logic [POS_W-1:0] position;
		logic [POS_W-1:0] preset0;
		logic [POS_W-1:0] preset1;
		logic [POS_W-1:0] target;
		dir_t             seek_dir;
		dir_t             drive_dir;
	} state_t;

	// One result item
	typedef struct packed {
		logic               seeking;
		logic [POS_W-1:0]   position_now;
		logic [LEVEL_W-1:0] down_pwm;
		logic [LEVEL_W-1:0] up_pwm;
	} result_t;

endpackage

FILE: rtl/epp_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder preset positioner: step logic
// Next state and result for one item, given the current state.
// ----------------------------------------------------------------------------
module epp_step (
	input  logic [epp_pkg::CMD_W-1:0]   cmd,
	input  logic                        enc_b,
	input  logic                        preset_slot,
	input  logic [epp_pkg::LEVEL_W-1:0] drive_level,
	input  epp_pkg::state_t             cur,
	output epp_pkg::state_t             nxt,
	output epp_pkg::result_t            res
);

	logic                      busy;
	logic [epp_pkg::POS_W-1:0] pos_step;
	logic [epp_pkg::POS_W-1:0] preset_sel;

	assign busy       = (cur.seek_dir != epp_pkg::DIR_NONE);
	assign pos_step   = enc_b ? (cur.position - 32'd1) : (cur.position + 32'd1);
	assign preset_sel = preset_slot ? cur.preset1 : cur.preset0;

	// Next state
	always_comb begin
		nxt = cur;
		if (cmd == epp_pkg::CMD_EDGE) begin
			nxt.position = pos_step;
			// seek ends on the first edge past the target
			if ((cur.seek_dir == epp_pkg::DIR_UP &&
			     $signed(pos_step) > $signed(cur.target)) ||
			    (cur.seek_dir == epp_pkg::DIR_DOWN &&
			     $signed(pos_step) < $signed(cur.target))) begin
				nxt.seek_dir  = epp_pkg::DIR_NONE;
				nxt.drive_dir = epp_pkg::DIR_NONE;
			end
		end else if (!busy) begin
			unique case (cmd)
				epp_pkg::CMD_UP:   nxt.drive_dir = epp_pkg::DIR_UP;
				epp_pkg::CMD_DOWN: nxt.drive_dir = epp_pkg::DIR_DOWN;
				epp_pkg::CMD_STOP: nxt.drive_dir = epp_pkg::DIR_NONE;
				epp_pkg::CMD_GOTO: begin
					nxt.target = preset_sel;
					priority if ($signed(cur.position) < $signed(preset_sel)) begin
						nxt.drive_dir = epp_pkg::DIR_UP;
						nxt.seek_dir  = epp_pkg::DIR_UP;
					end else if ($signed(cur.position) > $signed(preset_sel)) begin
						nxt.drive_dir = epp_pkg::DIR_DOWN;
						nxt.seek_dir  = epp_pkg::DIR_DOWN;
					end else begin
						nxt.drive_dir = epp_pkg::DIR_NONE;
						nxt.seek_dir  = epp_pkg::DIR_NONE;
					end
				end
				epp_pkg::CMD_SAVE: begin
					if (preset_slot) begin
						nxt.preset1 = cur.position;
					end else begin
						nxt.preset0 = cur.position;
					end
				end
				default: ; // unused codes, no change
			endcase
		end
	end

	// Result from the updated state
	always_comb begin
		res.up_pwm       = (nxt.drive_dir == epp_pkg::DIR_UP) ? drive_level : '0;
		res.down_pwm     = (nxt.drive_dir == epp_pkg::DIR_DOWN) ? drive_level : '0;
		res.position_now = nxt.position;
		res.seeking      = (nxt.seek_dir != epp_pkg::DIR_NONE);
	end

endmodule

FILE: rtl/encoder_preset_positioner_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder preset positioner core
// Position counter, two presets and a bang-bang seek toward a preset.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis: tuser holds the command (edge, up, down, stop,
//   go-to, save); tdata holds the encoder B level and the preset slot.
//   Output stream m_axis: one result per input item with both PWM duties,
//   the position after the item and the seek flag.
//   cfg_we/cfg_wdata write the drive duty; write it only while idle.
// Path: an input transfer passes the input register, then the result
//   register, before its result appears on m_axis.
// Throughput: one item per cycle while m_axis_tready is high; the state
//   update is a single add and signed compare between the two registers.
// Reset: position, presets and target clear to zero, motor stopped, no
//   seek, duty 255, both stream valids low.
// Stall: when m_axis_tready is low the result holds; one more item waits
//   in the input register, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module encoder_preset_positioner_core (
	input  logic        clk,
	input  logic        arst_n,
	// config
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,     // drive_level
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [0] enc_b, [1] preset_slot, rest zero
	input  logic [2:0]  s_axis_tuser,  // [2:0] command
	// output stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata   // [7:0] up_pwm, [15:8] down_pwm,
	                                   // [47:16] position_now, [48] seeking
);

	logic [epp_pkg::LEVEL_W-1:0] drive_level_q;
	epp_pkg::state_t             state_q;
	epp_pkg::state_t             state_nxt;
	epp_pkg::result_t            res_nxt;
	epp_pkg::result_t            res_s2;

	logic                        valid_s1;
	logic [epp_pkg::CMD_W-1:0]   cmd_s1;
	logic                        enc_b_s1;
	logic                        slot_s1;
	logic                        valid_s2;
	logic                        adv_s2;

	assign adv_s2        = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s2;

	// Config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_level_q <= epp_pkg::DRIVE_LEVEL_RST;
		end else if (cfg_we) begin
			drive_level_q <= cfg_wdata;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cmd_s1   <= s_axis_tuser;
			enc_b_s1 <= s_axis_tdata[0];
			slot_s1  <= s_axis_tdata[1];
		end
	end

	epp_step u_step (
		.cmd         (cmd_s1),
		.enc_b       (enc_b_s1),
		.preset_slot (slot_s1),
		.drive_level (drive_level_q),
		.cur         (state_q),
		.nxt         (state_nxt),
		.res         (res_nxt)
	);

	// State update on each item leaving the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{position: '0, preset0: '0, preset1: '0, target: '0,
			             seek_dir: epp_pkg::DIR_NONE, drive_dir: epp_pkg::DIR_NONE};
		end else if (adv_s2) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			res_s2 <= res_nxt;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {7'd0, res_s2};

endmodule

FILE: rtl/epp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder preset positioner: port checker
// Watches the core's ports over time; bound to the core below.
// ----------------------------------------------------------------------------
module epp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [55:0] m_axis_tdata
);

	// Never drive both directions at once
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[7:0] == 8'd0 || m_axis_tdata[15:8] == 8'd0))
		else $error("both direction duties nonzero");

	// No result right after reset release
	assert property (@(posedge clk) $rose(arst_n) |-> !m_axis_tvalid)
		else $error("result valid out of reset");

	// A stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	// Pad bits of the result stay zero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[55:49] == 7'd0)
		else $error("result pad bits set");

endmodule

bind encoder_preset_positioner_core epp_checker u_epp_checker (.*);

FILE: bench/encoder_preset_positioner_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder preset positioner core: testbench
// A short directed stimulus table, then random command streams that mostly
// follow save / go-to / edge sequences, so seeks run to their overshoot stop.
// Every result is checked field by field: typed directed rows against a
// hand-worked result, all others against an in-bench model of the positioner.
// Three stall patterns run, and the drive duty is rewritten before each.
// ----------------------------------------------------------------------------
module encoder_preset_positioner_core_tb;
	import epp_pkg::*;

	// Command codes outside the defined set: the core only reports a result on them, with no state change
	localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

	localparam int DIRECTED_N  = 25;
	localparam int PHASE_ITEMS = 610;
	localparam int PRINT_CAP   = 40;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [7:0]  cfg_wdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [0] enc_b, [1] preset_slot, rest zero
	logic [2:0]  s_axis_tuser;   // [2:0] command
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [55:0] m_axis_tdata;   // [7:0] up_pwm, [15:8] down_pwm,
	                             // [47:16] position_now, [48] seeking

	always #5 clk = ~clk;

	encoder_preset_positioner_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// Model state of the positioner
	logic signed [POS_W-1:0] pos_q;
	logic signed [POS_W-1:0] preset_q [2];
	logic signed [POS_W-1:0] target_q;
	dir_t                    seek_dir_q;
	dir_t                    drive_dir_q;
	logic [LEVEL_W-1:0]      duty_q;

	// Results owed by the core, oldest first
	result_t pending_results [$];

	int err_count;
	int items_sent;
	int results_seen;
	int seeks_started;
	int seeks_landed;
	int duty_writes;
	int send_idle_pct;
	int recv_idle_pct;

	// Directed stimulus; typed rows carry a hand-worked result
	typedef struct {
		logic [CMD_W-1:0]   cmd;
		logic               enc_b;
		logic               slot;
		bit                 typed;
		logic [LEVEL_W-1:0] up;
		logic [LEVEL_W-1:0] down;
		logic signed [31:0] pos;
		logic               seek;
	} stim_row_t;

	stim_row_t directed_tbl [DIRECTED_N] = '{
		'{CMD_STOP,   1'b0, 1'b0, 1'b1, 8'h00, 8'h00,  32'sd0, 1'b0},
		'{CMD_EDGE,   1'b0, 1'b0, 1'b1, 8'h00, 8'h00,  32'sd1, 1'b0},
		'{CMD_UP,     1'b0, 1'b0, 1'b1, 8'hFF, 8'h00,  32'sd1, 1'b0},
		'{CMD_EDGE,   1'b1, 1'b0, 1'b1, 8'hFF, 8'h00,  32'sd0, 1'b0},
		'{CMD_DOWN,   1'b0, 1'b0, 1'b1, 8'h00, 8'hFF,  32'sd0, 1'b0},
		'{CMD_EDGE,   1'b1, 1'b0, 1'b1, 8'h00, 8'hFF, -32'sd1, 1'b0},
		'{CMD_SAVE,   1'b1, 1'b1, 1'b0, 8'h00, 8'h00,  32'sd0, 1'b0},
		'{CMD_SPARE6, 1'b1, 1'b1, 1'b0, 8'h00, 8'h00,  32'sd0, 1'b0},
		'{CMD_SPARE7, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00,  32'sd0, 1'b0},
		'{CMD_STOP,   1'b0, 1'b0, 1'b0, 8'h00, 8'h00,  32'sd0, 1'b0},
		'{CMD_EDGE,   1'b0, 1'b0, 1'b0, 8'h00, 8'h00,  32'sd0, 1'b0},
		'{CMD_EDGE,   1'b0, 1'b1, 1'b0, 8'h00, 8'h00,  32'sd0, 1'b0},
		// seek down toward slot 1, buttons ignored on the way
		'{CMD_GOTO,   1'b0, 1'b1, 1'b0, 8'h00, 8'h00,  32'sd0, 1'b0},
		'{CMD_UP,     1'b0, 1'b0, 1'b0, 8'h00, 8'h00,  32'sd0, 1'b0},
		'{CMD_SAVE,   1'b0, 1'b0, 1'b0, 8'h00, 8'h00,  32'sd0, 1'b0},
		'{CMD_EDGE,   1'b0, 1'b0, 1'b0, 8'h00, 8'h00,  32'sd0, 1'b0},
		'{CMD_EDGE,   1'b1, 1'b0, 1'b0, 8'h00, 8'h00,  32'sd0, 1'b0},
		'{CMD_EDGE,   1'b1, 1'b0, 1'b0, 8'h00, 8'h00,  32'sd0, 1'b0},
		'{CMD_EDGE,   1'b1, 1'b0, 1'b0, 8'h00, 8'h00,  32'sd0, 1'b0},
		'{CMD_EDGE,   1'b1, 1'b0, 1'b0, 8'h00, 8'h00,  32'sd0, 1'b0},
		// go-to onto the current position stops without a seek
		'{CMD_SAVE,   1'b0, 1'b0, 1'b0, 8'h00, 8'h00,  32'sd0, 1'b0},
		'{CMD_GOTO,   1'b1, 1'b0, 1'b0, 8'h00, 8'h00,  32'sd0, 1'b0},
		// short seek up, ends one count past the target
		'{CMD_GOTO,   1'b0, 1'b1, 1'b0, 8'h00, 8'h00,  32'sd0, 1'b0},
		'{CMD_EDGE,   1'b0, 1'b0, 1'b0, 8'h00, 8'h00,  32'sd0, 1'b0},
		'{CMD_EDGE,   1'b0, 1'b1, 1'b0, 8'h00, 8'h00,  32'sd0, 1'b0}
	};

	task automatic report_mismatch(input string what, input longint got, input longint want);
		if (err_count < PRINT_CAP)
			$display("%0t ns: %s mismatch, got %0h expected %0h", $time, what, got, want);
		err_count++;
	endtask

	// Advance the positioner model by one item and form its result
	task automatic step_positioner(input logic [CMD_W-1:0] cmd, input logic enc_b,
		input logic slot, output result_t r);
		logic busy;
		busy = (seek_dir_q != DIR_NONE);
		if (cmd == CMD_EDGE) begin
			pos_q = enc_b ? pos_q - 32'sd1 : pos_q + 32'sd1;
			// seek ends on the first edge past the target
			if ((seek_dir_q == DIR_UP && pos_q > target_q) ||
			    (seek_dir_q == DIR_DOWN && pos_q < target_q)) begin
				seek_dir_q  = DIR_NONE;
				drive_dir_q = DIR_NONE;
				seeks_landed++;
			end
		end else if (!busy) begin
			case (cmd)
				CMD_UP:   drive_dir_q = DIR_UP;
				CMD_DOWN: drive_dir_q = DIR_DOWN;
				CMD_STOP: drive_dir_q = DIR_NONE;
				CMD_GOTO: begin
					target_q = preset_q[slot];
					if (pos_q < target_q) begin
						drive_dir_q = DIR_UP;
						seek_dir_q  = DIR_UP;
						seeks_started++;
					end else if (pos_q > target_q) begin
						drive_dir_q = DIR_DOWN;
						seek_dir_q  = DIR_DOWN;
						seeks_started++;
					end else begin
						drive_dir_q = DIR_NONE;
						seek_dir_q  = DIR_NONE;
					end
				end
				CMD_SAVE: preset_q[slot] = pos_q;
				default: ;
			endcase
		end
		r.up_pwm       = (drive_dir_q == DIR_UP) ? duty_q : '0;
		r.down_pwm     = (drive_dir_q == DIR_DOWN) ? duty_q : '0;
		r.position_now = pos_q;
		r.seeking      = (seek_dir_q != DIR_NONE);
	endtask

	// One input transfer, with random sender gaps ahead of it
	task automatic send_item(input logic [CMD_W-1:0] cmd, input logic enc_b, input logic slot,
		input bit typed, input result_t typed_r);
		result_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {6'd0, slot, enc_b};
		s_axis_tuser  <= cmd;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		step_positioner(cmd, enc_b, slot, r);
		pending_results.push_back(typed ? typed_r : r);
		items_sent++;
	endtask

	// Random item; mostly follows the motion so seeks reach their target
	task automatic pick_random(output logic [CMD_W-1:0] cmd, output logic enc_b,
		output logic slot);
		int roll;
		roll  = $urandom_range(99);
		enc_b = 1'($urandom_range(1));
		slot  = 1'($urandom_range(1));
		if (seek_dir_q != DIR_NONE) begin
			if (roll < 85) begin
				cmd   = CMD_EDGE;
				enc_b = (seek_dir_q == DIR_DOWN);
			end else if (roll < 93)
				cmd = CMD_EDGE;
			else
				cmd = CMD_W'($urandom_range(7, 1));
		end else begin
			if (roll < 35) begin
				cmd = CMD_EDGE;
				if (drive_dir_q != DIR_NONE && $urandom_range(3) != 0)
					enc_b = (drive_dir_q == DIR_DOWN);
			end else if (roll < 55)
				cmd = CMD_GOTO;
			else if (roll < 70)
				cmd = CMD_SAVE;
			else if (roll < 92)
				cmd = CMD_W'($urandom_range(3, 1));
			else
				cmd = (roll[0]) ? CMD_SPARE6 : CMD_SPARE7;
		end
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_duty(input logic [LEVEL_W-1:0] level);
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= level;
		@(posedge clk);
		cfg_we <= 1'b0;
		duty_q = level;
		duty_writes++;
	endtask

	// Receiver stalls
	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

	// Result checker
	always @(posedge clk) begin : result_check
		result_t got;
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = result_t'(m_axis_tdata[48:0]);
			if (pending_results.size() == 0)
				report_mismatch("unexpected result", longint'(m_axis_tdata), longint'(0));
			else begin
				want = pending_results.pop_front();
				results_seen++;
				if (got.up_pwm !== want.up_pwm)
					report_mismatch("up_pwm", longint'(got.up_pwm),
						longint'(want.up_pwm));
				if (got.down_pwm !== want.down_pwm)
					report_mismatch("down_pwm", longint'(got.down_pwm),
						longint'(want.down_pwm));
				if (got.position_now !== want.position_now)
					report_mismatch("position_now", longint'(got.position_now),
						longint'(want.position_now));
				if (got.seeking !== want.seeking)
					report_mismatch("seeking", longint'(got.seeking),
						longint'(want.seeking));
				if (m_axis_tdata[55:49] !== 7'd0)
					report_mismatch("tdata padding", longint'(m_axis_tdata[55:49]),
						longint'(0));
			end
		end
	end

	// Stimulus and end of run
	initial begin : stimulus
		logic [CMD_W-1:0]   cmd;
		logic               enc_b;
		logic               slot;
		result_t            typed_r;
		logic [LEVEL_W-1:0] phase_duty [3];

		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		err_count     = 0;
		items_sent    = 0;
		results_seen  = 0;
		seeks_started = 0;
		seeks_landed  = 0;
		duty_writes   = 0;
		pos_q         = '0;
		preset_q[0]   = '0;
		preset_q[1]   = '0;
		target_q      = '0;
		seek_dir_q    = DIR_NONE;
		drive_dir_q   = DIR_NONE;
		duty_q        = DRIVE_LEVEL_RST;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table at the reset duty
		foreach (directed_tbl[i]) begin
			typed_r.up_pwm       = directed_tbl[i].up;
			typed_r.down_pwm     = directed_tbl[i].down;
			typed_r.position_now = directed_tbl[i].pos;
			typed_r.seeking      = directed_tbl[i].seek;
			send_item(directed_tbl[i].cmd, directed_tbl[i].enc_b, directed_tbl[i].slot,
				directed_tbl[i].typed, typed_r);
		end

		// Random phases: duty at both extremes and one in between
		phase_duty[0] = 8'h00;
		phase_duty[1] = 8'hFF;
		phase_duty[2] = LEVEL_W'($urandom_range(254, 1));
		for (int ph = 0; ph < 3; ph++) begin
			write_duty(phase_duty[ph]);
			send_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 71 : 0;
			recv_idle_pct = (ph == 0) ? 71 : (ph == 1) ? 9 : 0;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// hold the sender off mid-phase until the core has emptied
				if (n == PHASE_ITEMS / 2)
					wait_drained();
				pick_random(cmd, enc_b, slot);
				send_item(cmd, enc_b, slot, 1'b0, typed_r);
			end
		end

		wait_drained();
		repeat (10) @(posedge clk);

		$display("Run covered %0d items and %0d checked results over three stall patterns.",
			items_sent, results_seen);
		$display("Seeks started %0d, ended by overshoot %0d, duty writes %0d, mismatches %0d.",
			seeks_started, seeks_landed, duty_writes, err_count);
		if (err_count == 0)
			$display("[encoder_preset_positioner_core] OK");
		else
			$display("[encoder_preset_positioner_core] ERROR");
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("[encoder_preset_positioner_core] ERROR");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/epp_pkg.sv
rtl/epp_step.sv
rtl/encoder_preset_positioner_core.sv
rtl/epp_checker.sv
bench/encoder_preset_positioner_core_tb.sv
